[hw/rtl/cdc_pkg.sv]
package cdc_pkg;

	localparam int WINDOW_BYTES_DEF = 48;

	localparam logic [31:0] BOUNDARY_MASK_RST = 32'd8191;
	localparam logic [31:0] HASH_MULT_RST     = 32'd31;
	localparam logic [31:0] MULT_POWER_RST    = 32'd0;

	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOUNDARY_MASK = 2'd0,
		REG_HASH_MULT     = 2'd1,
		REG_MULT_POWER    = 2'd2,
		REG_UNUSED        = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL1 = 4'b0010,
		ST_MUL2 = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	typedef enum logic {
		MUL_SEL_OLDEST = 1'b0,
		MUL_SEL_HASH   = 1'b1
	} mul_sel_t;

	typedef struct packed {
		logic     en;
		mul_sel_t sel;
	} mul_ctrl_t;

endpackage

[hw/rtl/cdc_ram.sv]
module cdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

[hw/rtl/cdc_mul.sv]
module cdc_mul (
	input  logic              clk,
	input  cdc_pkg::mul_ctrl_t ctrl,
	input  logic [7:0]        oldest,
	input  logic [31:0]       power,
	input  logic [31:0]       mult,
	input  logic [31:0]       acc,
	output logic [31:0]       prod_q
);

	logic [31:0] op_a;
	logic [31:0] op_b;

	always_comb begin
		unique case (ctrl.sel)
			cdc_pkg::MUL_SEL_OLDEST: begin
				op_a = {24'd0, oldest};
				op_b = power;
			end
			cdc_pkg::MUL_SEL_HASH: begin
				op_a = mult;
				op_b = acc;
			end
			default: begin
				op_a = mult;
				op_b = acc;
			end
		endcase
	end

	// low 32 bits of the product only
	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			prod_q <= op_a * op_b;
		end
	end

endmodule

[hw/rtl/content_defined_chunker.sv]
// An input byte is accepted only in ST_IDLE; no new byte is taken until the
// last one is through the window memory read and two passes through the
// single shared 32x32 multiplier (oldest*m^W, then m*acc); a boundary waits
// in ST_DONE while the previous result has not been taken.
// Reset (arst_n low, asynchronous): control and config registers reset,
// window empty, hash and length zero; byte/result regs and memory not reset.
module content_defined_chunker #(
	parameter int WINDOW_BYTES = cdc_pkg::WINDOW_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  data_byte,
	input  logic                        stream_end,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [31:0]                 chunk_length,
	output logic                        closed_by_stream_end,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [cdc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                 cfg_data
);

	localparam int PTR_W  = $clog2(WINDOW_BYTES);
	localparam int FILL_W = $clog2(WINDOW_BYTES + 1);

	cdc_pkg::state_t    state_q;
	cdc_pkg::mul_ctrl_t mul_ctrl;

	logic [31:0]       mask_q;
	logic [31:0]       mult_q;
	logic [31:0]       power_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic [31:0]       hash_q;
	logic [31:0]       len_q;
	logic [7:0]        byte_q;
	logic              last_q;
	logic              full_q;
	logic              out_valid_q;
	logic [31:0]       chunk_length_q;
	logic              closed_q;

	logic [7:0]  oldest;
	logic [31:0] acc;
	logic [31:0] prod_q;
	logic        window_full;
	logic        match;
	logic        emit;
	logic        done_go;
	logic        accept;

	assign cfg_ready            = 1'b1;
	assign in_ready             = (state_q == cdc_pkg::ST_IDLE);
	assign accept               = in_valid && in_ready;
	assign out_valid            = out_valid_q;
	assign chunk_length         = chunk_length_q;
	assign closed_by_stream_end = closed_q;

	assign window_full = (fill_q == FILL_W'(WINDOW_BYTES));
	assign acc = full_q ? (hash_q - prod_q + {24'd0, byte_q}) : (hash_q + {24'd0, byte_q});
	assign match   = window_full && ((prod_q & mask_q) == 32'd0);
	assign emit    = match || last_q;
	assign done_go = (state_q == cdc_pkg::ST_DONE) && (!emit || !out_valid_q || out_ready);

	always_comb begin
		mul_ctrl.en  = 1'b0;
		mul_ctrl.sel = cdc_pkg::MUL_SEL_OLDEST;
		unique case (state_q)
			cdc_pkg::ST_MUL1: begin
				mul_ctrl.en  = 1'b1;
				mul_ctrl.sel = cdc_pkg::MUL_SEL_OLDEST;
			end
			cdc_pkg::ST_MUL2: begin
				mul_ctrl.en  = 1'b1;
				mul_ctrl.sel = cdc_pkg::MUL_SEL_HASH;
			end
			default: begin
				mul_ctrl.en  = 1'b0;
				mul_ctrl.sel = cdc_pkg::MUL_SEL_OLDEST;
			end
		endcase
	end

	cdc_ram #(
		.WIDTH (8),
		.DEPTH (WINDOW_BYTES)
	) u_window (
		.clk     (clk),
		.we      (state_q == cdc_pkg::ST_MUL1),
		.waddr   (ptr_q),
		.wdata   (byte_q),
		.re      (accept),
		.raddr   (ptr_q),
		.rdata_q (oldest)
	);

	cdc_mul u_mul (
		.clk    (clk),
		.ctrl   (mul_ctrl),
		.oldest (oldest),
		.power  (power_q),
		.mult   (mult_q),
		.acc    (acc),
		.prod_q (prod_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= cdc_pkg::BOUNDARY_MASK_RST;
			mult_q  <= cdc_pkg::HASH_MULT_RST;
			power_q <= cdc_pkg::MULT_POWER_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cdc_pkg::REG_BOUNDARY_MASK: mask_q  <= cfg_data;
				cdc_pkg::REG_HASH_MULT:     mult_q  <= cfg_data;
				cdc_pkg::REG_MULT_POWER:    power_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= data_byte;
			last_q <= stream_end;
		end
		if (done_go && emit) begin
			chunk_length_q <= len_q;
			closed_q       <= !match;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cdc_pkg::ST_IDLE;
			ptr_q       <= '0;
			fill_q      <= '0;
			hash_q      <= '0;
			len_q       <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (done_go && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				cdc_pkg::ST_IDLE: begin
					if (accept) begin
						if (len_q != 32'hFFFF_FFFF) begin
							len_q <= len_q + 32'd1;
						end
						full_q  <= window_full;
						state_q <= cdc_pkg::ST_MUL1;
					end
				end
				cdc_pkg::ST_MUL1: begin
					ptr_q   <= (ptr_q == PTR_W'(WINDOW_BYTES - 1)) ? '0 : ptr_q + PTR_W'(1);
					state_q <= cdc_pkg::ST_MUL2;
				end
				cdc_pkg::ST_MUL2: begin
					if (!full_q) begin
						fill_q <= fill_q + FILL_W'(1);
					end
					state_q <= cdc_pkg::ST_DONE;
				end
				cdc_pkg::ST_DONE: begin
					if (done_go) begin
						if (emit) begin
							ptr_q  <= '0;
							fill_q <= '0;
							hash_q <= '0;
							len_q  <= '0;
						end else begin
							hash_q <= prod_q;
						end
						state_q <= cdc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= cdc_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule
